@@ rtl/aes_pkg.sv @@
// AES-128 CTR package: S-box, round helpers, stage payload type.
// Used by all modules of aes128_ctr_decrypt_top.
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int BLK_W      = 128;
    localparam int CNT_W      = 5;

    typedef struct packed {
        logic             valid;
        logic [BLK_W-1:0] state;
        logic [BLK_W-1:0] rkey;
        logic [BLK_W-1:0] ctext;
        logic [CNT_W-1:0] nbytes;
        logic             last;
    } t_cell;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
            4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
            4'd9: r = 8'h1b; 4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block, byte 0 in the top bits
    function automatic logic [7:0] get_b(input logic [BLK_W-1:0] v, input int i);
        return v[BLK_W-1-8*i -: 8];
    endfunction

    // next round key from the current one
    function automatic logic [BLK_W-1:0] next_key(input logic [BLK_W-1:0] k,
                                                  input logic [3:0] rnd);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows and (unless final) MixColumns
    function automatic logic [BLK_W-1:0] round_fn(input logic [BLK_W-1:0] s,
                                                  input logic final_rnd);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [BLK_W-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*c] = sbox(get_b(s, r + 4*((c + r) & 3)));
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (final_rnd) begin
                o[BLK_W-1-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[BLK_W-1-32*c -: 32] = {
                    xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                    xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return o;
    endfunction

endpackage

@@ rtl/aes_cell.sv @@
// One AES round cell: round function plus on-the-fly key schedule.
// Depends on aes_pkg.
module aes_cell import aes_pkg::*; #(
    parameter logic [3:0] RND = 4'd1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);
    t_cell            r_cell;
    logic [BLK_W-1:0] w_key;

    assign w_key = next_key(i_cell.rkey, RND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= i_cell.valid;
        end
        if (i_en) begin
            r_cell.state  <= round_fn(i_cell.state, RND == 4'(NUM_ROUNDS)) ^ w_key;
            r_cell.rkey   <= w_key;
            r_cell.ctext  <= i_cell.ctext;
            r_cell.nbytes <= i_cell.nbytes;
            r_cell.last   <= i_cell.last;
        end
    end

    assign o_cell = r_cell;
endmodule

@@ rtl/aes128_ctr_decrypt_top.sv @@
// AES-128 CTR decrypt, top level: input stage, ten round cells, output stage.
// Depends on aes_pkg and aes_cell.
//
//  channel  dir  fields (low bit first)
//  s_axis   in   tdata: block_high[63:0] block_low[127:64] valid_bytes[132:128];
//                 tlast: last_block; tuser: func
//  m_axis   out  tdata: plain_high[63:0] plain_low[127:64] plain_bytes[132:128];
//                 tlast: end_of_message
//  cfg      in   i_cfg_we, i_cfg_idx (0 key_high, 1 key_low), i_cfg_data
//
// One word per cycle while m_axis does not stall. Pipeline: input stage, ten
// round cells, output register. The chain advances as one whole whenever the
// output register is free or being emptied; a stall on m_axis freezes every
// cell. Counter loads give no word; they take an input slot and leave an empty
// slot in the chain. Reset clears valid bits, counter and key.
module aes128_ctr_decrypt_top import aes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // block_high, block_low, valid_bytes
    input  logic         s_axis_tlast,   // last_block
    input  logic         s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // plain_high, plain_low, plain_bytes
    output logic         m_axis_tlast,   // end_of_message
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;
    localparam logic FUNC_LOAD    = 1'b0;

    logic [63:0]  r_key_high, r_key_low;
    logic [127:0] r_ctr;
    logic         w_en, w_acc;
    t_cell        r_in;
    t_cell        w_chain [NUM_ROUNDS+1];
    logic         r_ovalid;
    logic [127:0] r_plain;
    logic [4:0]   r_pbytes;
    logic         r_plast;
    logic [127:0] w_ks, w_mask, w_pt;
    logic [4:0]   w_nb;

    // whole chain moves when the output slot is free or drained
    assign w_en          = !r_ovalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      r_key_high <= r_key_high;
            endcase
        end
    end

    // counter and input stage (round 0: add whitening key)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr    <= '0;
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= w_acc && (s_axis_tuser != FUNC_LOAD);
            if (w_acc) begin
                if (s_axis_tuser == FUNC_LOAD)
                    r_ctr <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                else
                    r_ctr <= r_ctr + 128'd1;
            end
        end
        if (w_en) begin
            r_in.state  <= r_ctr ^ {r_key_high, r_key_low};
            r_in.rkey   <= {r_key_high, r_key_low};
            r_in.ctext  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            r_in.nbytes <= s_axis_tdata[132:128];
            r_in.last   <= s_axis_tlast;
        end
    end

    assign w_chain[0] = r_in;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
        aes_cell #(.RND(4'(g + 1))) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    // byte mask from the valid count, above sixteen means all
    assign w_ks = w_chain[NUM_ROUNDS].state;
    assign w_nb = w_chain[NUM_ROUNDS].nbytes;
    always_comb begin
        for (int i = 0; i < 16; i++)
            w_mask[127-8*i -: 8] = (5'(i) < w_nb) ? 8'hff : 8'h00;
    end
    assign w_pt = (w_chain[NUM_ROUNDS].ctext ^ w_ks) & w_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= w_chain[NUM_ROUNDS].valid;
        end
        if (w_en) begin
            r_plain  <= w_pt;
            r_pbytes <= w_nb;
            r_plast  <= w_chain[NUM_ROUNDS].last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_pbytes, r_plain[63:0], r_plain[127:64]};
    assign m_axis_tlast  = r_plast;

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_plain))
        else $error("output word lost under stall");
    // counter only moves on an accepted word
    a_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_ctr))
        else $error("counter moved without input");
    // a decrypt word always advances the counter by one
    a_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && s_axis_tuser && $past(i_rst_n) |=> r_ctr == $past(r_ctr) + 128'd1)
        else $error("counter increment wrong");
endmodule

@@ verif/aes128_ctr_decrypt_checker.sv @@
// Shared codes and the scoreboard for the AES-128 CTR decrypt testbench.
// Watches the s_axis, m_axis and cfg ports, predicts every plaintext word and compares.
// Depends on nothing but the ports of aes128_ctr_decrypt_top.
`timescale 1ns / 100ps

package ctr_tb_defs;
    typedef enum logic { FUNC_LOAD = 1'b0, FUNC_DECRYPT = 1'b1 } t_func;
    typedef enum logic { REG_KEY_HIGH = 1'b0, REG_KEY_LOW = 1'b1 } t_reg;
endpackage

module aes128_ctr_decrypt_checker import ctr_tb_defs::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // block_high, block_low, valid_bytes
    input  logic         s_axis_tlast,   // last_block
    input  logic         s_axis_tuser,   // func
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,   // plain_high, plain_low, plain_bytes
    input  logic         m_axis_tlast,   // end_of_message
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending
);

    typedef struct {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic [4:0]  plain_bytes;
        logic        end_of_msg;
    } t_plain_word;

    t_plain_word  plain_q[$];
    logic [127:0] key_model;
    logic [127:0] ctr_model;

    // GF(2^8) helpers; S-box built from the field inverse plus the affine map
    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] a);
        logic [7:0] inv, r;
        inv = 8'h01;
        for (int i = 0; i < 254; i++) inv = gf_mul(inv, a);   // a^254, zero stays zero
        r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return r;
    endfunction

    function automatic logic [127:0] aes_keystream(input logic [127:0] key,
                                                   input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] rk [16];
        logic [7:0] w [4];
        logic [7:0] rc, a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127-8*i -: 8];
            s[i]  = blk[127-8*i -: 8] ^ rk[i];
        end
        rc = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++) begin
            w[0] = sub_byte(rk[13]) ^ rc;
            w[1] = sub_byte(rk[14]);
            w[2] = sub_byte(rk[15]);
            w[3] = sub_byte(rk[12]);
            for (int i = 0; i < 16; i++) rk[i] = rk[i] ^ (i < 4 ? w[i] : rk[i-4]);
            rc = gf_dbl(rc);
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[r + 4*c] = sub_byte(s[r + 4*((c + r) & 3)]);
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                if (rnd == 10) begin
                    s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
                end else begin
                    s[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
                    s[4*c+1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
                    s[4*c+2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
                    s[4*c+3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
                end
            end
            for (int i = 0; i < 16; i++) s[i] ^= rk[i];
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [127:0] got,
                                   input logic [127:0] want);
        o_errors++;
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    assign o_pending = plain_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_plain_word  exp_w;
        logic [127:0] ks, ct, pt;
        int           n_keep;
        if (!i_rst_n) begin
            key_model <= '0;
            ctr_model <= '0;
            plain_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_KEY_HIGH) key_model[127:64] <= i_cfg_data;
                else                           key_model[63:0]   <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == FUNC_LOAD) begin
                    ctr_model <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                end else begin
                    ks = aes_keystream(key_model, ctr_model);
                    ct = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                    n_keep = s_axis_tdata[132:128] > 16 ? 16 : s_axis_tdata[132:128];
                    pt = '0;
                    for (int i = 0; i < 16; i++)
                        if (i < n_keep) pt[127-8*i -: 8] = ct[127-8*i -: 8] ^ ks[127-8*i -: 8];
                    exp_w.plain_high  = pt[127:64];
                    exp_w.plain_low   = pt[63:0];
                    exp_w.plain_bytes = s_axis_tdata[132:128];
                    exp_w.end_of_msg  = s_axis_tlast;
                    plain_q = {plain_q, exp_w};
                    ctr_model <= ctr_model + 128'd1;   // wraps at all-ones
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (plain_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata[127:0], '0);
                end else begin
                    exp_w = plain_q.pop_front();
                    if (m_axis_tdata[63:0] !== exp_w.plain_high)
                        report_mismatch("plain_high", 128'(m_axis_tdata[63:0]),
                                        128'(exp_w.plain_high));
                    if (m_axis_tdata[127:64] !== exp_w.plain_low)
                        report_mismatch("plain_low", 128'(m_axis_tdata[127:64]),
                                        128'(exp_w.plain_low));
                    if (m_axis_tdata[132:128] !== exp_w.plain_bytes)
                        report_mismatch("plain_bytes", 128'(m_axis_tdata[132:128]),
                                        128'(exp_w.plain_bytes));
                    if (m_axis_tlast !== exp_w.end_of_msg)
                        report_mismatch("end_of_message", 128'(m_axis_tlast),
                                        128'(exp_w.end_of_msg));
                end
            end
        end
    end

endmodule

@@ verif/tb_aes128_ctr_decrypt_top.sv @@
// Testbench top for aes128_ctr_decrypt_top: clock, reset, stimulus, verdict.
// Depends on aes128_ctr_decrypt_checker.sv (ctr_tb_defs and the scoreboard).
`timescale 1ns / 100ps

module tb_aes128_ctr_decrypt_top;
    import ctr_tb_defs::*;

    localparam int IDLE_LIMIT  = 5000;  // cycles without any handshake
    localparam int DRAIN_WAIT  = 20;    // outlasts the pipe latency
    localparam int RANDOM_ITEMS = 400;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // block_high, block_low, valid_bytes
    logic         s_axis_tlast;   // last_block
    logic         s_axis_tuser;   // func
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;   // plain_high, plain_low, plain_bytes
    logic         m_axis_tlast;   // end_of_message
    logic         i_cfg_we;
    logic         i_cfg_idx;
    logic [63:0]  i_cfg_data;

    int errors;
    int pending;
    int idle_cycles;
    bit send_quiet;     // sender: no gaps
    bit recv_quiet;     // receiver: no stalls
    bit recv_hold;      // receiver: one long hold-off
    int words_sent;

    aes128_ctr_decrypt_top uut (.*);

    aes128_ctr_decrypt_checker chk (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: nothing moving on either stream for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, quiet stretches, one long hold-off on request
    initial begin
        int w;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = recv_quiet ? 0 : $urandom_range(0, 17);
            if (recv_hold) begin
                w = 300;
                recv_hold = 1'b0;
            end
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // one word on s_axis; valid stays up into the next word when there is no gap
    task automatic send_word(input t_func fn, input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] nb, input logic last);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {3'b000, nb, lo, hi};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // key writes only with the pipe empty; loads leave no word, so wait out latency too
    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_KEY_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_idx  <= REG_KEY_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // a well-formed message: counter load, then full blocks, last one maybe partial
    task automatic send_message(input int n_blocks);
        logic [4:0] nb;
        send_word(FUNC_LOAD, rand64(), ($urandom_range(0, 3) == 0) ? 64'hffff_ffff_ffff_fffe
                                                                   : rand64(),
                  5'($urandom), 1'($urandom));
        for (int b = 0; b < n_blocks; b++) begin
            nb = (b == n_blocks - 1) ? 5'($urandom_range(1, 16)) : 5'd16;
            send_word(FUNC_DECRYPT, rand64(), rand64(), nb, b == n_blocks - 1);
        end
    endtask

    initial begin
        int roll;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = FUNC_LOAD;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_KEY_HIGH;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        idle_cycles   = 0;
        send_quiet    = 1'b0;
        recv_quiet    = 1'b0;
        recv_hold     = 1'b0;
        words_sent    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset key (all zero) and reset counter, no load first
        send_word(FUNC_DECRYPT, '0, '0, 5'd16, 1'b0);
        send_word(FUNC_DECRYPT, '1, '1, 5'd1, 1'b1);

        // standard CTR test vector key and counter block
        load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_word(FUNC_LOAD, 64'hf0f1f2f3f4f5f6f7, 64'hf8f9fafbfcfdfeff, 5'd31, 1'b1);
        send_word(FUNC_DECRYPT, 64'h874d6191b620e326, 64'h1bef6864990db6ce, 5'd16, 1'b0);
        send_word(FUNC_DECRYPT, 64'h9806f66b7970fdff, 64'h8617187bb9fffdff, 5'd16, 1'b0);
        // valid count of zero, above sixteen and the top of the field
        send_word(FUNC_DECRYPT, '1, '1, 5'd0, 1'b0);
        send_word(FUNC_DECRYPT, '1, '1, 5'd17, 1'b0);
        send_word(FUNC_DECRYPT, '1, '1, 5'd31, 1'b1);
        // carry from the low half into the high half
        send_word(FUNC_LOAD, 64'h0123456789abcdef, '1, 5'd0, 1'b0);
        send_word(FUNC_DECRYPT, '0, '0, 5'd8, 1'b0);
        send_word(FUNC_DECRYPT, '0, '0, 5'd9, 1'b1);
        // all-ones counter wraps to zero
        send_word(FUNC_LOAD, '1, '1, 5'd16, 1'b1);
        send_word(FUNC_DECRYPT, '0, '1, 5'd15, 1'b0);
        send_word(FUNC_DECRYPT, '1, '0, 5'd16, 1'b1);

        // all-ones key
        load_key('1, '1);
        send_word(FUNC_LOAD, '0, '0, 5'd1, 1'b0);
        send_word(FUNC_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd16, 1'b1);
        send_word(FUNC_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd2, 1'b0);

        // random phases, each under a fresh key
        words_sent = 0;
        for (int phase = 0; words_sent < RANDOM_ITEMS; phase++) begin
            case (phase % 5)
                0: load_key(rand64(), rand64());
                1: load_key('0, rand64());
                2: load_key(rand64(), '1);
                default: load_key(rand64(), rand64());
            endcase
            send_quiet = (phase % 3 == 1);
            recv_quiet = (phase % 4 == 2);
            if (phase == 2) begin
                // back-pressure: receiver stalls long while sender streams on
                send_quiet = 1'b1;
                recv_hold  = 1'b1;
                send_message(30);
            end
            for (int m = 0; m < 6; m++) begin
                roll = $urandom_range(0, 9);
                if (roll < 7) begin
                    send_message($urandom_range(1, 10));
                end else begin
                    // noise: any func, any count, any last marker
                    repeat ($urandom_range(1, 6))
                        send_word(t_func'($urandom_range(0, 1)), rand64(), rand64(),
                                  5'($urandom), 1'($urandom));
                end
            end
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/aes_pkg.sv
rtl/aes_cell.sv
rtl/aes128_ctr_decrypt_top.sv
verif/aes128_ctr_decrypt_checker.sv
verif/tb_aes128_ctr_decrypt_top.sv
